// ----- hdl/rsdt_pkg.sv -----
// Shared types and fixed field widths for the receive session descriptor tracker.
// No dependencies; used by rsdt_ctrl, rsdt_dp and the top level.
package rsdt_pkg;

	localparam int SID_W   = 9;
	localparam int FRAG_W  = 23;
	localparam int ADDR_W  = 64;
	localparam int WORD_W  = 32;
	localparam int TAG_W   = 64;

	// result kind codes
	localparam logic KIND_DMA    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// notification action codes
	localparam logic ACT_END   = 1'b0;
	localparam logic ACT_START = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clear;   // write an inactive entry at the sweep pointer
		logic load;    // capture the input transaction and read its entry
		logic commit;  // write back the entry, if changed, and emit the result, if any
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;  // sweep pointer is at the last entry
		logic stall;       // result pending but the output register is still full
	} dp_status_t;

endpackage

// ----- hdl/rx_session_descriptor_tracker_top.sv -----
// Receive session descriptor tracker, top level.
// A load accepts the transaction and does the registered read of its descriptor memory entry;
// the EXEC state writes the entry back and registers the result; in_ready is low until it commits.
// A full output register that is not being read holds a transaction with a result in EXEC until taken.
// After reset a sweep marks every session inactive; in_ready is low during the sweep.
// Instantiates rsdt_ctrl and rsdt_dp; depends on rsdt_pkg.
module rx_session_descriptor_tracker_top #(
	parameter int SESSIONS     = 512,
	parameter int LENGTH_BITS  = 23,
	parameter int ADDRESS_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rsdt_pkg::SID_W-1:0]        sess_num,
	input  logic                              action,
	input  logic [rsdt_pkg::FRAG_W-1:0]       frag_length,
	input  logic [rsdt_pkg::ADDR_W-1:0]       buf_address,
	input  logic [rsdt_pkg::WORD_W-1:0]       rx_buf_idx,
	input  logic [rsdt_pkg::WORD_W-1:0]       header_count,
	input  logic [rsdt_pkg::TAG_W-1:0]        header_rest,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic [rsdt_pkg::ADDR_W-1:0]       dma_address,
	output logic [rsdt_pkg::FRAG_W-1:0]       dma_length,
	output logic [rsdt_pkg::SID_W-1:0]        status_session,
	output logic                              status_first,
	output logic                              status_last,
	output logic [rsdt_pkg::WORD_W-1:0]       done_rx_buf_idx,
	output logic [rsdt_pkg::WORD_W-1:0]       done_header_count,
	output logic [rsdt_pkg::TAG_W-1:0]        done_header_rest,
	output logic                              overrun
);

	rsdt_pkg::ctl_cmd_t   cmd;
	rsdt_pkg::dp_status_t sts;

	rsdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsdt_dp #(
		.SESSIONS     (SESSIONS),
		.LENGTH_BITS  (LENGTH_BITS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.sess_num          (sess_num),
		.action            (action),
		.frag_length       (frag_length),
		.buf_address       (buf_address),
		.rx_buf_idx        (rx_buf_idx),
		.header_count      (header_count),
		.header_rest       (header_rest),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.dma_address       (dma_address),
		.dma_length        (dma_length),
		.status_session    (status_session),
		.status_first      (status_first),
		.status_last       (status_last),
		.done_rx_buf_idx   (done_rx_buf_idx),
		.done_header_count (done_header_count),
		.done_header_rest  (done_header_rest),
		.overrun           (overrun)
	);

endmodule

// ----- hdl/rsdt_ctrl.sv -----
// Controller state machine: reset sweep, transaction accept, write-back sequencing.
// Depends on rsdt_pkg.
module rsdt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rsdt_pkg::dp_status_t  sts,
	output rsdt_pkg::ctl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit = (state_q == ST_EXEC) && !sts.stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (!sts.stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

// ----- hdl/rsdt_dp.sv -----
// Datapath: session descriptor memory, input capture, update logic, output register.
// Depends on rsdt_pkg; driven by rsdt_ctrl through ctl_cmd_t / dp_status_t.
module rsdt_dp #(
	parameter int SESSIONS     = 512,
	parameter int LENGTH_BITS  = 23,
	parameter int ADDRESS_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsdt_pkg::ctl_cmd_t                cmd,
	output rsdt_pkg::dp_status_t              sts,
	input  logic [rsdt_pkg::SID_W-1:0]        sess_num,
	input  logic                              action,
	input  logic [rsdt_pkg::FRAG_W-1:0]       frag_length,
	input  logic [rsdt_pkg::ADDR_W-1:0]       buf_address,
	input  logic [rsdt_pkg::WORD_W-1:0]       rx_buf_idx,
	input  logic [rsdt_pkg::WORD_W-1:0]       header_count,
	input  logic [rsdt_pkg::TAG_W-1:0]        header_rest,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic [rsdt_pkg::ADDR_W-1:0]       dma_address,
	output logic [rsdt_pkg::FRAG_W-1:0]       dma_length,
	output logic [rsdt_pkg::SID_W-1:0]        status_session,
	output logic                              status_first,
	output logic                              status_last,
	output logic [rsdt_pkg::WORD_W-1:0]       done_rx_buf_idx,
	output logic [rsdt_pkg::WORD_W-1:0]       done_header_count,
	output logic [rsdt_pkg::TAG_W-1:0]        done_header_rest,
	output logic                              overrun
);

	localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam logic [rsdt_pkg::FRAG_W-1:0] LEN_MASK =
		(LENGTH_BITS >= rsdt_pkg::FRAG_W) ? {rsdt_pkg::FRAG_W{1'b1}}
		: rsdt_pkg::FRAG_W'((64'd1 << LENGTH_BITS) - 64'd1);

	typedef struct packed {
		logic                        active;
		logic                        first;
		logic [ADDRESS_BITS-1:0]     address;
		logic [rsdt_pkg::WORD_W-1:0] remaining;
		logic [rsdt_pkg::WORD_W-1:0] rx_buf_idx;
		logic [rsdt_pkg::WORD_W-1:0] header_count;
		logic [rsdt_pkg::TAG_W-1:0]  header_rest;
	} entry_t;

	entry_t mem [SESSIONS];
	entry_t rd_q;

	logic [IDX_W-1:0]              clr_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          in_range_q;
	logic                          action_q;
	logic [rsdt_pkg::FRAG_W-1:0]   len_q;
	logic [rsdt_pkg::SID_W-1:0]    sid_q;
	logic [ADDRESS_BITS-1:0]       addr_in_q;
	logic [rsdt_pkg::WORD_W-1:0]   bidx_in_q;
	logic [rsdt_pkg::WORD_W-1:0]   hcnt_in_q;
	logic [rsdt_pkg::TAG_W-1:0]    hrest_in_q;

	logic                          out_valid_q;

	// next-state and result logic for the transaction in flight
	entry_t                        new_entry;
	logic                          wr_entry;
	logic                          emit;
	logic [rsdt_pkg::WORD_W-1:0]   len32;
	logic [rsdt_pkg::WORD_W-1:0]   rem_next;
	logic                          over;
	logic                          last;
	logic                          kind_d;
	logic [rsdt_pkg::ADDR_W-1:0]   dma_address_d;
	logic [rsdt_pkg::FRAG_W-1:0]   dma_length_d;
	logic [rsdt_pkg::SID_W-1:0]    status_session_d;
	logic                          status_first_d;
	logic                          status_last_d;
	logic [rsdt_pkg::WORD_W-1:0]   done_rx_buf_idx_d;
	logic [rsdt_pkg::WORD_W-1:0]   done_header_count_d;
	logic [rsdt_pkg::TAG_W-1:0]    done_header_rest_d;
	logic                          overrun_d;

	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	entry_t                        wr_data;

	assign len32    = rsdt_pkg::WORD_W'(len_q);
	assign rem_next = rd_q.remaining - len32;
	assign over     = rd_q.remaining < len32;
	assign last     = (rem_next == '0);

	always_comb begin
		new_entry           = rd_q;
		wr_entry            = 1'b0;
		emit                = 1'b0;
		kind_d              = rsdt_pkg::KIND_DMA;
		dma_address_d       = '0;
		dma_length_d        = '0;
		status_session_d    = '0;
		status_first_d      = 1'b0;
		status_last_d       = 1'b0;
		done_rx_buf_idx_d   = '0;
		done_header_count_d = '0;
		done_header_rest_d  = '0;
		overrun_d           = 1'b0;
		if (in_range_q) begin
			if (!rd_q.active) begin
				// open the session; no result
				wr_entry               = 1'b1;
				new_entry.active       = 1'b1;
				new_entry.first        = 1'b1;
				new_entry.address      = addr_in_q;
				new_entry.remaining    = hcnt_in_q;
				new_entry.rx_buf_idx   = bidx_in_q;
				new_entry.header_count = hcnt_in_q;
				new_entry.header_rest  = hrest_in_q;
			end else if (action_q == rsdt_pkg::ACT_START) begin
				emit          = 1'b1;
				kind_d        = rsdt_pkg::KIND_DMA;
				dma_address_d = rsdt_pkg::ADDR_W'(rd_q.address);
				dma_length_d  = len_q;
			end else begin
				wr_entry            = 1'b1;
				emit                = 1'b1;
				new_entry.address   = rd_q.address + ADDRESS_BITS'(len_q);
				new_entry.remaining = rem_next;
				new_entry.first     = 1'b0;
				new_entry.active    = !last;
				kind_d              = rsdt_pkg::KIND_STATUS;
				status_session_d    = sid_q;
				status_first_d      = rd_q.first;
				status_last_d       = last;
				overrun_d           = over;
				if (last) begin
					done_rx_buf_idx_d   = rd_q.rx_buf_idx;
					done_header_count_d = rd_q.header_count;
					done_header_rest_d  = rd_q.header_rest;
				end
			end
		end
	end

	assign sts.stall      = emit && out_valid_q && !out_ready;
	assign sts.clear_done = (clr_q == IDX_W'(SESSIONS - 1));

	assign wr_en   = cmd.clear || (cmd.commit && wr_entry);
	assign wr_addr = cmd.clear ? clr_q : idx_q;
	assign wr_data = cmd.clear ? entry_t'('0) : new_entry;

	// descriptor memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.load) rd_q <= mem[IDX_W'(sess_num)];
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q      <= IDX_W'(sess_num);
			in_range_q <= (32'(sess_num) < 32'(SESSIONS));
			action_q   <= action;
			len_q      <= frag_length & LEN_MASK;
			sid_q      <= sess_num;
			addr_in_q  <= buf_address[ADDRESS_BITS-1:0];
			bidx_in_q  <= rx_buf_idx;
			hcnt_in_q  <= header_count;
			hrest_in_q <= header_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear && !sts.clear_done) clr_q <= clr_q + 1'b1;
			if (cmd.commit && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.commit && emit) begin
			kind              <= kind_d;
			dma_address       <= dma_address_d;
			dma_length        <= dma_length_d;
			status_session    <= status_session_d;
			status_first      <= status_first_d;
			status_last       <= status_last_d;
			done_rx_buf_idx   <= done_rx_buf_idx_d;
			done_header_count <= done_header_count_d;
			done_header_rest  <= done_header_rest_d;
			overrun           <= overrun_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- tb/rx_session_descriptor_tracker_top_tb.sv -----
// Self-checking testbench for the receive session descriptor tracker top level.
// Runs a directed table and then random session traffic, checking every output against
// the table or a cycle-free predictor. Depends on rsdt_pkg and rx_session_descriptor_tracker_top.
module rx_session_descriptor_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SESSIONS  = 512;
	localparam int RANDOM_NOTIFS = 1400;
	localparam int QUIET_LIMIT   = 4000;
	localparam logic [31:0] MAX_FRAG = 32'h007F_FFFF;

	typedef struct packed {
		logic [rsdt_pkg::SID_W-1:0]  sess_num;
		logic                        action;
		logic [rsdt_pkg::FRAG_W-1:0] frag_length;
		logic [rsdt_pkg::ADDR_W-1:0] buf_address;
		logic [rsdt_pkg::WORD_W-1:0] rx_buf_idx;
		logic [rsdt_pkg::WORD_W-1:0] header_count;
		logic [rsdt_pkg::TAG_W-1:0]  header_rest;
	} notif_t;

	typedef struct packed {
		logic                        kind;
		logic [rsdt_pkg::ADDR_W-1:0] dma_address;
		logic [rsdt_pkg::FRAG_W-1:0] dma_length;
		logic [rsdt_pkg::SID_W-1:0]  status_session;
		logic                        status_first;
		logic                        status_last;
		logic [rsdt_pkg::WORD_W-1:0] done_rx_buf_idx;
		logic [rsdt_pkg::WORD_W-1:0] done_header_count;
		logic [rsdt_pkg::TAG_W-1:0]  done_header_rest;
		logic                        overrun;
	} instr_t;

	// typed: expected instruction written in the row; has_instr: row yields one
	typedef struct packed {
		notif_t notif;
		logic   typed;
		logic   has_instr;
		instr_t instr;
	} dir_row_t;

	localparam instr_t NO_INSTR = '0;
	localparam int DIR_N = 23;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		// open the top session with every field at its maximum
		'{'{9'h1FF, rsdt_pkg::ACT_START, 23'h7FFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
			1'b1, 1'b0, NO_INSTR},
		'{'{9'h1FF, rsdt_pkg::ACT_START, 23'h7FFFFF, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_DMA, 64'hFFFF_FFFF_FFFF_FFFF, 23'h7FFFFF, 9'h0, 1'b0, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		// address wraps past the top
		'{'{9'h1FF, rsdt_pkg::ACT_END, 23'h7FFFFF, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h1FF, 1'b1, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		'{'{9'h1FF, rsdt_pkg::ACT_START, 23'h0, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_DMA, 64'h0000_0000_007F_FFFE, 23'h0, 9'h0, 1'b0, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		'{'{9'h1FF, rsdt_pkg::ACT_END, 23'h0, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h1FF, 1'b0, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		// zero-byte message closes on an empty end of fragment
		'{'{9'h000, rsdt_pkg::ACT_END, 23'h0, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b0, NO_INSTR},
		'{'{9'h000, rsdt_pkg::ACT_END, 23'h0, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h000, 1'b1, 1'b1,
			32'h0, 32'h0, 64'h0, 1'b0}},
		// two-fragment message on a reopened session
		'{'{9'h000, rsdt_pkg::ACT_END, 23'h7FFFFF, 64'h1000, 32'hA5A5_0001, 32'd100,
			64'hDEAD_BEEF_0123_4567}, 1'b1, 1'b0, NO_INSTR},
		'{'{9'h000, rsdt_pkg::ACT_START, 23'd40, 64'hFFFF_0000_FFFF_0000, 32'h1234_5678,
			32'd7, 64'h0F0F}, 1'b1, 1'b1,
			'{rsdt_pkg::KIND_DMA, 64'h1000, 23'd40, 9'h0, 1'b0, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		'{'{9'h000, rsdt_pkg::ACT_END, 23'd40, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h000, 1'b1, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		'{'{9'h000, rsdt_pkg::ACT_START, 23'd60, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_DMA, 64'h1028, 23'd60, 9'h0, 1'b0, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b0}},
		'{'{9'h000, rsdt_pkg::ACT_END, 23'd60, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h000, 1'b0, 1'b1,
			32'hA5A5_0001, 32'd100, 64'hDEAD_BEEF_0123_4567, 1'b0}},
		// overshoot wraps the remaining count and keeps the session open
		'{'{9'h002, rsdt_pkg::ACT_START, 23'h0, 64'h2000, 32'h7, 32'd10, 64'h1},
			1'b1, 1'b0, NO_INSTR},
		'{'{9'h002, rsdt_pkg::ACT_END, 23'd20, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b1, 1'b1,
			'{rsdt_pkg::KIND_STATUS, 64'h0, 23'h0, 9'h002, 1'b1, 1'b0,
			32'h0, 32'h0, 64'h0, 1'b1}},
		'{'{9'h002, rsdt_pkg::ACT_END, 23'h0, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h002, rsdt_pkg::ACT_START, 23'h5, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h0AA, rsdt_pkg::ACT_END, 23'h0, 64'hFFFF_FFFF_FFFF_FFF0, 32'h5555_5555,
			32'd1, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, 1'b0, NO_INSTR},
		'{'{9'h0AA, rsdt_pkg::ACT_START, 23'h2AAAAA, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h0AA, rsdt_pkg::ACT_END, 23'd1, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h155, rsdt_pkg::ACT_END, 23'h0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
			32'h0055_5555, 64'h5555_5555_5555_5555}, 1'b0, 1'b0, NO_INSTR},
		'{'{9'h155, rsdt_pkg::ACT_END, 23'h555555, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h002, rsdt_pkg::ACT_END, 23'h7FFFFF, 64'h0, 32'h0, 32'h0, 64'h0},
			1'b0, 1'b0, NO_INSTR},
		'{'{9'h0AA, rsdt_pkg::ACT_START, 23'h1, 64'h8000_0000_0000_0000, 32'h8000_0000,
			32'h8000_0000, 64'h8000_0000_0000_0001}, 1'b0, 1'b0, NO_INSTR}
	};

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [rsdt_pkg::SID_W-1:0]  sess_num = '0;
	logic                        action = rsdt_pkg::ACT_END;
	logic [rsdt_pkg::FRAG_W-1:0] frag_length = '0;
	logic [rsdt_pkg::ADDR_W-1:0] buf_address = '0;
	logic [rsdt_pkg::WORD_W-1:0] rx_buf_idx = '0;
	logic [rsdt_pkg::WORD_W-1:0] header_count = '0;
	logic [rsdt_pkg::TAG_W-1:0]  header_rest = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        kind;
	logic [rsdt_pkg::ADDR_W-1:0] dma_address;
	logic [rsdt_pkg::FRAG_W-1:0] dma_length;
	logic [rsdt_pkg::SID_W-1:0]  status_session;
	logic                        status_first;
	logic                        status_last;
	logic [rsdt_pkg::WORD_W-1:0] done_rx_buf_idx;
	logic [rsdt_pkg::WORD_W-1:0] done_header_count;
	logic [rsdt_pkg::TAG_W-1:0]  done_header_rest;
	logic                        overrun;

	rx_session_descriptor_tracker_top dut (.*);

	// predicted descriptor table
	bit                          desc_open  [NUM_SESSIONS];
	bit                          desc_first [NUM_SESSIONS];
	logic [rsdt_pkg::ADDR_W-1:0] desc_addr  [NUM_SESSIONS];
	logic [31:0]                 desc_left  [NUM_SESSIONS];
	logic [rsdt_pkg::WORD_W-1:0] desc_buf   [NUM_SESSIONS];
	logic [rsdt_pkg::WORD_W-1:0] desc_count [NUM_SESSIONS];
	logic [rsdt_pkg::TAG_W-1:0]  desc_tag   [NUM_SESSIONS];

	// stimulus bookkeeping: a start of fragment waiting for its end
	bit                          frag_open [NUM_SESSIONS];
	logic [rsdt_pkg::FRAG_W-1:0] frag_len  [NUM_SESSIONS];
	logic [rsdt_pkg::SID_W-1:0]  busy_sids [8];

	instr_t pending_instr [$];
	int     mismatches = 0;
	bit     calm = 1'b0;
	int     quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic bit track_notification(input notif_t n, output instr_t r);
		logic [31:0]                left_next;
		logic [rsdt_pkg::SID_W-1:0] s;
		r = '0;
		s = n.sess_num;
		if (!desc_open[s]) begin
			desc_open[s]  = 1'b1;
			desc_first[s] = 1'b1;
			desc_addr[s]  = n.buf_address;
			desc_left[s]  = n.header_count;
			desc_buf[s]   = n.rx_buf_idx;
			desc_count[s] = n.header_count;
			desc_tag[s]   = n.header_rest;
			return 1'b0;
		end
		if (n.action == rsdt_pkg::ACT_START) begin
			r.kind        = rsdt_pkg::KIND_DMA;
			r.dma_address = desc_addr[s];
			r.dma_length  = n.frag_length;
			return 1'b1;
		end
		left_next        = desc_left[s] - 32'(n.frag_length);
		r.kind           = rsdt_pkg::KIND_STATUS;
		r.status_session = s;
		r.status_first   = desc_first[s];
		r.status_last    = (left_next == 32'h0);
		r.overrun        = (desc_left[s] < 32'(n.frag_length));
		desc_addr[s]     = desc_addr[s] + rsdt_pkg::ADDR_W'(n.frag_length);
		desc_left[s]     = left_next;
		desc_first[s]    = 1'b0;
		if (r.status_last) begin
			r.done_rx_buf_idx   = desc_buf[s];
			r.done_header_count = desc_count[s];
			r.done_header_rest  = desc_tag[s];
			desc_open[s]        = 1'b0;
		end
		return 1'b1;
	endfunction

	// mostly start/end pairs with matching lengths, some noise and overshoot
	function automatic notif_t next_notification();
		notif_t                     n;
		int unsigned                pick;
		int                         slot;
		logic [rsdt_pkg::SID_W-1:0] s;
		slot = $urandom_range(7);
		s = busy_sids[slot];
		if ($urandom_range(99) < 3 ||
				(desc_open[s] && desc_left[s] > MAX_FRAG && $urandom_range(1) == 1)) begin
			busy_sids[slot] = rsdt_pkg::SID_W'($urandom_range(NUM_SESSIONS - 1));
			s = busy_sids[slot];
		end
		n.sess_num    = s;
		n.action      = 1'($urandom_range(1));
		n.frag_length = rsdt_pkg::FRAG_W'($urandom_range(MAX_FRAG));
		n.buf_address = {$urandom, $urandom};
		n.rx_buf_idx  = $urandom;
		n.header_rest = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (!desc_open[s]) begin
			if (pick < 70)
				n.header_count = $urandom_range(20000);
			else if (pick < 90)
				n.header_count = $urandom_range(3 * MAX_FRAG);
			else
				n.header_count = $urandom;
			frag_open[s] = 1'b0;
		end else begin
			n.header_count = $urandom;
			if (frag_open[s] && pick < 85) begin
				n.action      = rsdt_pkg::ACT_END;
				n.frag_length = frag_len[s];
			end else if (desc_left[s] <= MAX_FRAG && pick < 95) begin
				if ($urandom_range(1) == 1)
					n.frag_length = desc_left[s][rsdt_pkg::FRAG_W-1:0];
				else
					n.frag_length = rsdt_pkg::FRAG_W'($urandom_range(desc_left[s]));
			end
			frag_open[s] = (n.action == rsdt_pkg::ACT_START);
			frag_len[s]  = n.frag_length;
		end
		return n;
	endfunction

	function automatic int field_differs(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// idle at random, optionally drain, then hold one transaction until it is taken
	task automatic send_notification(input notif_t n, input bit drain);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 37)
				gap++;
		if (gap != 0 || drain)
			in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
		if (drain)
			do @(posedge clk); while (pending_instr.size() != 0);
		in_valid     <= 1'b1;
		sess_num     <= n.sess_num;
		action       <= n.action;
		frag_length  <= n.frag_length;
		buf_address  <= n.buf_address;
		rx_buf_idx   <= n.rx_buf_idx;
		header_count <= n.header_count;
		header_rest  <= n.header_rest;
		do @(posedge clk); while (!in_ready);
	endtask

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 37);

	always @(posedge clk) begin
		instr_t got;
		instr_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, dma_address, dma_length, status_session, status_first, status_last,
				done_rx_buf_idx, done_header_count, done_header_rest, overrun};
			if (pending_instr.size() == 0) begin
				$display("%0t: unexpected instruction, expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = pending_instr.pop_front();
				mismatches += field_differs("kind", 64'(want.kind), 64'(got.kind))
					+ field_differs("dma_address", want.dma_address, got.dma_address)
					+ field_differs("dma_length", 64'(want.dma_length), 64'(got.dma_length))
					+ field_differs("status_session", 64'(want.status_session),
						64'(got.status_session))
					+ field_differs("status_first", 64'(want.status_first),
						64'(got.status_first))
					+ field_differs("status_last", 64'(want.status_last), 64'(got.status_last))
					+ field_differs("done_rx_buf_idx", 64'(want.done_rx_buf_idx),
						64'(got.done_rx_buf_idx))
					+ field_differs("done_header_count", 64'(want.done_header_count),
						64'(got.done_header_count))
					+ field_differs("done_header_rest", want.done_header_rest,
						got.done_header_rest)
					+ field_differs("overrun", 64'(want.overrun), 64'(got.overrun));
			end
		end
	end

	// give up after a long stretch with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		notif_t n;
		instr_t predicted;
		bit     hit;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			send_notification(DIR_TAB[i].notif, 1'b0);
			hit = track_notification(DIR_TAB[i].notif, predicted);
			if (DIR_TAB[i].typed) begin
				if (DIR_TAB[i].has_instr)
					pending_instr.push_back(DIR_TAB[i].instr);
			end else if (hit) begin
				pending_instr.push_back(predicted);
			end
		end

		foreach (busy_sids[k])
			busy_sids[k] = rsdt_pkg::SID_W'($urandom_range(NUM_SESSIONS - 1));
		for (int i = 0; i < RANDOM_NOTIFS; i++) begin
			calm = (i >= 500 && i < 720);
			n = next_notification();
			send_notification(n, i == 0 || i == 300 || i == 1000);
			if (track_notification(n, predicted))
				pending_instr.push_back(predicted);
		end
		in_valid <= 1'b0;

		while (pending_instr.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rsdt_pkg.sv
hdl/rsdt_ctrl.sv
hdl/rsdt_dp.sv
hdl/rx_session_descriptor_tracker_top.sv
tb/rx_session_descriptor_tracker_top_tb.sv
